FILE: hw/rtl/csa_pkg.sv
// ----------------------------------------------------------------------------
// csa_pkg
// Shared constants, codes and types for the chunked slot allocator.
// ----------------------------------------------------------------------------
package csa_pkg;

    localparam int SLOTS_PER_CHUNK = 16;
    localparam int MAX_CHUNKS      = 8;
    localparam int POOL_SLOTS      = SLOTS_PER_CHUNK * MAX_CHUNKS;

    localparam int SLOT_W   = (SLOTS_PER_CHUNK > 1) ? $clog2(SLOTS_PER_CHUNK) : 1;
    localparam int CHUNK_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int POOL_AW  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int TOP_W    = $clog2(SLOTS_PER_CHUNK + 1);
    localparam int ACT_W    = $clog2(MAX_CHUNKS + 1);
    localparam int CFG_W    = 5;
    localparam int HANDLE_W = 7;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;

    // stream payload widths, rounded up to whole bytes
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [CFG_W-1:0] CHUNK_SLOTS_RESET = CFG_W'(16);

    // requests from the controller into the slot store
    typedef struct packed {
        logic               rd_en;
        logic [POOL_AW-1:0] fs_raddr;
        logic [POOL_AW-1:0] iu_raddr;
        logic               fs_we;
        logic [POOL_AW-1:0] fs_waddr;
        logic [SLOT_W-1:0]  fs_wdata;
        logic               iu_we;
        logic [POOL_AW-1:0] iu_waddr;
        logic               iu_wdata;
    } t_mem_req;

    // registered read results, reset values already resolved
    typedef struct packed {
        logic [SLOT_W-1:0] fs_data;
        logic              in_use;
    } t_mem_rsp;

endpackage

FILE: hw/rtl/chunked_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// chunked_slot_allocator_core
// Fixed-size slot allocator: per-chunk free stacks in memory, chunks brought
// into use on demand, one status result per request.
// ----------------------------------------------------------------------------
//  channel     direction  payload
//  s_axis      in         tdata: handle[6:0]; tuser: kind (0 alloc, 1 free)
//  m_axis      out        tdata: status[1:0], granted_handle[8:2],
//                                allocated_count[16:9]
//  cfg         in         i_cfg_wdata: chunk_slots, written when i_cfg_we
//
//  a request has a read step, which picks the chunk and reads the free-stack
//  and in-use memories, and an update step for memories, stack tops and count.
//  a new request is taken only once the last one has finished its update step;
//  a result held by m_axis_tready low stalls the update step.
//  reset is synchronous; memory contents are covered by per-entry valid
//  bits cleared at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module chunked_slot_allocator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [csa_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // handle, zero pad
    input  logic                            s_axis_tuser,   // kind
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [csa_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // status, granted_handle,
                                                            // allocated_count, zero pad
    input  logic                            i_cfg_we,
    input  logic [csa_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import csa_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;

    logic [CFG_W-1:0]   r_chunk_slots;
    logic [TOP_W-1:0]   r_top [MAX_CHUNKS];
    logic [ACT_W-1:0]   r_active;
    logic [COUNT_W-1:0] r_count;

    // request held between the read and update cycles
    logic               r_kind;
    logic [CHUNK_W-1:0] r_chunk;
    logic [TOP_W-1:0]   r_new_top;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_full;
    logic               r_bad;
    logic               r_fresh;

    logic                 r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;

    t_mem_req mem_req;
    t_mem_rsp mem_rsp;

    logic               accept;
    logic               fire;
    logic [TOP_W-1:0]   limit;
    logic               found;
    logic [CHUNK_W-1:0] sel;
    logic [CHUNK_W-1:0] a_chunk;
    logic [TOP_W-1:0]   a_top;
    logic               a_full;
    logic               a_fresh;
    logic [HANDLE_W-1:0] in_handle;
    logic [CHUNK_W-1:0] f_chunk;
    logic               f_bad;
    logic [TOP_W-1:0]   f_top;
    logic               alloc_ok;
    logic               free_ok;
    logic [HANDLE_W-1:0] granted;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0] n_count;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign fire      = (r_state == ST_EXEC) && (!r_m_valid || m_axis_tready);
    assign in_handle = s_axis_tdata[HANDLE_W-1:0];

    always_comb begin
        if (r_chunk_slots == '0) begin
            limit = TOP_W'(1);
        end else if (r_chunk_slots > CFG_W'(SLOTS_PER_CHUNK)) begin
            limit = TOP_W'(SLOTS_PER_CHUNK);
        end else begin
            limit = TOP_W'(r_chunk_slots);
        end
    end

    // first active chunk with room left
    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int i = 0; i < MAX_CHUNKS; i++) begin
            if (!found && (ACT_W'(i) < r_active) && (r_top[i] < limit)) begin
                found = 1'b1;
                sel   = CHUNK_W'(i);
            end
        end
    end

    // an inactive chunk still has reset contents, so it needs no reload
    always_comb begin
        a_fresh = 1'b0;
        a_full  = 1'b0;
        a_chunk = sel;
        if (!found) begin
            if (r_active < ACT_W'(MAX_CHUNKS)) begin
                a_fresh = 1'b1;
                a_chunk = r_active[CHUNK_W-1:0];
            end else begin
                a_full = 1'b1;
            end
        end
        a_top = a_fresh ? '0 : r_top[a_chunk];
    end

    assign f_chunk = in_handle[HANDLE_W-1 -: CHUNK_W];
    assign f_top   = r_top[f_chunk];
    assign f_bad   = (ACT_W'(f_chunk) >= r_active) || (f_top == '0);

    assign alloc_ok = (r_kind == KIND_ALLOC) && !r_full;
    assign free_ok  = (r_kind == KIND_FREE) && !r_bad && mem_rsp.in_use;
    assign granted  = alloc_ok ? {r_chunk, mem_rsp.fs_data} : '0;

    always_comb begin
        if (r_kind == KIND_ALLOC) begin
            status = r_full ? STATUS_FULL : STATUS_OK;
        end else begin
            status = free_ok ? STATUS_OK : STATUS_BAD_FREE;
        end
        n_count = r_count;
        if (alloc_ok) begin
            n_count = r_count + COUNT_W'(1);
        end else if (free_ok && (r_count != '0)) begin
            n_count = r_count - COUNT_W'(1);
        end
    end

    always_comb begin
        mem_req          = '0;
        mem_req.rd_en    = accept;
        mem_req.fs_raddr = {a_chunk, a_top[SLOT_W-1:0]};
        mem_req.iu_raddr = in_handle;
        if (fire && alloc_ok) begin
            mem_req.iu_we    = 1'b1;
            mem_req.iu_waddr = {r_chunk, mem_rsp.fs_data};
            mem_req.iu_wdata = 1'b1;
        end else if (fire && free_ok) begin
            mem_req.iu_we    = 1'b1;
            mem_req.iu_waddr = {r_chunk, r_slot};
            mem_req.iu_wdata = 1'b0;
            mem_req.fs_we    = 1'b1;
            mem_req.fs_waddr = {r_chunk, r_new_top[SLOT_W-1:0]};
            mem_req.fs_wdata = r_slot;
        end
    end

    csa_slot_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rsp   (mem_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= s_axis_tuser;
            r_slot  <= in_handle[SLOT_W-1:0];
            r_fresh <= a_fresh;
            r_full  <= a_full;
            if (s_axis_tuser == KIND_ALLOC) begin
                r_chunk   <= a_chunk;
                r_new_top <= a_top + TOP_W'(1);
                r_bad     <= 1'b0;
            end else begin
                r_chunk   <= f_chunk;
                r_new_top <= f_top - TOP_W'(1);
                r_bad     <= f_bad;
            end
        end
        if (fire) begin
            r_m_data <= M_TDATA_W'({n_count, granted, status});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_chunk_slots <= CHUNK_SLOTS_RESET;
            r_active      <= ACT_W'(1);
            r_count       <= '0;
            r_m_valid     <= 1'b0;
            for (int i = 0; i < MAX_CHUNKS; i++) begin
                r_top[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_chunk_slots <= i_cfg_wdata;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (fire) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (fire) begin
                r_count <= n_count;
                if (alloc_ok || free_ok) begin
                    r_top[r_chunk] <= r_new_top;
                end
                if (alloc_ok && r_fresh) begin
                    r_active <= r_active + ACT_W'(1);
                end
            end
            if (fire) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

FILE: hw/rtl/csa_slot_store.sv
// ----------------------------------------------------------------------------
// csa_slot_store
// Free-stack and in-use memories with per-entry valid bits standing in for
// the reset contents; registered reads.
// ----------------------------------------------------------------------------
module csa_slot_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  csa_pkg::t_mem_req i_req,
    output csa_pkg::t_mem_rsp o_rsp
);
    import csa_pkg::*;

    logic [SLOT_W-1:0] fs_mem [POOL_SLOTS];
    logic              iu_mem [POOL_SLOTS];

    logic [POOL_SLOTS-1:0] r_fs_vld;
    logic [POOL_SLOTS-1:0] r_iu_vld;

    logic [SLOT_W-1:0] r_fs_q;
    logic [SLOT_W-1:0] r_fs_dflt;
    logic              r_fs_v;
    logic              r_iu_q;
    logic              r_iu_v;

    always_ff @(posedge i_clk) begin
        if (i_req.fs_we) begin
            fs_mem[i_req.fs_waddr] <= i_req.fs_wdata;
        end
        if (i_req.iu_we) begin
            iu_mem[i_req.iu_waddr] <= i_req.iu_wdata;
        end
        if (i_req.rd_en) begin
            r_fs_q    <= fs_mem[i_req.fs_raddr];
            r_fs_dflt <= i_req.fs_raddr[SLOT_W-1:0];
            r_iu_q    <= iu_mem[i_req.iu_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs_vld <= '0;
            r_iu_vld <= '0;
            r_fs_v   <= 1'b0;
            r_iu_v   <= 1'b0;
        end else begin
            if (i_req.fs_we) begin
                r_fs_vld[i_req.fs_waddr] <= 1'b1;
            end
            if (i_req.iu_we) begin
                r_iu_vld[i_req.iu_waddr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_fs_v <= r_fs_vld[i_req.fs_raddr];
                r_iu_v <= r_iu_vld[i_req.iu_raddr];
            end
        end
    end

    // unwritten stack entry i of a chunk holds i, unwritten mark reads as free
    assign o_rsp.fs_data = r_fs_v ? r_fs_q : r_fs_dflt;
    assign o_rsp.in_use  = r_iu_v & r_iu_q;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for chunked_slot_allocator_core. A short directed list
// walks reset values, chunk sizes at and beyond their limits, pool exhaustion
// and bad frees. Random phases follow, each under its own chunk size, mixing
// frees of held slots with allocates and stray frees. Every result is checked
// against a local model of the free stacks, or a fixed value on typed rows.
// Both stream sides idle at random, one long receiver hold backs up the input.
// ----------------------------------------------------------------------------
module testbench;
    import csa_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] granted;
        logic [COUNT_W-1:0]  count;
    } alloc_result_t;

    typedef enum logic {ROW_CFG, ROW_REQ} row_kind_e;

    typedef struct {
        row_kind_e           what;
        logic [CFG_W-1:0]    cfg;
        logic                kind;
        logic [HANDLE_W-1:0] handle;
        bit                  typed;
        alloc_result_t       want;
    } plan_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // handle, zero pad
    logic                  s_axis_tuser;   // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // status, granted_handle, allocated_count, pad
    logic                  i_cfg_we;
    logic [CFG_W-1:0]      i_cfg_wdata;

    // model of the pool
    logic [SLOT_W-1:0]   pool_stack [POOL_SLOTS];
    logic [TOP_W-1:0]    pool_top   [MAX_CHUNKS];
    bit                  slot_held  [POOL_SLOTS];
    int                  live_chunks;
    int                  held_total;
    logic [CFG_W-1:0]    chunk_size;

    alloc_result_t awaited_grants [$];
    plan_row_t     directed_rows [$];
    int            fail_count;
    bit            tx_idle_on;
    bit            rx_idle_on;
    int            long_hold_req;
    int            long_hold_seen;

    chunked_slot_allocator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void reload_chunk(input int c);
        for (int k = 0; k < SLOTS_PER_CHUNK; k++) begin
            pool_stack[c * SLOTS_PER_CHUNK + k] = SLOT_W'(k);
            slot_held[c * SLOTS_PER_CHUNK + k]  = 1'b0;
        end
        pool_top[c] = '0;
    endfunction

    // applies one request to the pool model and returns its outcome
    function automatic alloc_result_t allocator_step(input logic kind,
                                                     input logic [HANDLE_W-1:0] h);
        alloc_result_t r;
        int            lim;
        int            pick;
        int            c;
        int            slot;
        int            g;
        bit            hit;
        r    = '0;
        hit  = 1'b0;
        pick = 0;
        r.status = STATUS_OK;
        if (kind == KIND_ALLOC) begin
            if (chunk_size == 0)
                lim = 1;
            else if (chunk_size > SLOTS_PER_CHUNK)
                lim = SLOTS_PER_CHUNK;
            else
                lim = chunk_size;
            for (c = 0; c < live_chunks; c++) begin
                if (!hit && pool_top[c] < lim) begin
                    hit  = 1'b1;
                    pick = c;
                end
            end
            if (!hit) begin
                if (live_chunks < MAX_CHUNKS) begin
                    pick = live_chunks;
                    reload_chunk(pick);
                    live_chunks++;
                    hit = 1'b1;
                end else begin
                    r.status = STATUS_FULL;
                end
            end
            if (hit) begin
                slot = pool_stack[pick * SLOTS_PER_CHUNK + pool_top[pick]];
                g    = pick * SLOTS_PER_CHUNK + slot;
                slot_held[g]   = 1'b1;
                pool_top[pick] = pool_top[pick] + 1'b1;
                held_total++;
                r.granted = HANDLE_W'(g);
            end
        end else begin
            c    = h / SLOTS_PER_CHUNK;
            slot = h % SLOTS_PER_CHUNK;
            if (c >= live_chunks) begin
                r.status = STATUS_BAD_FREE;
            end else if (!slot_held[h] || pool_top[c] == 0) begin
                r.status = STATUS_BAD_FREE;
            end else begin
                pool_top[c] = pool_top[c] - 1'b1;
                slot_held[h] = 1'b0;
                pool_stack[c * SLOTS_PER_CHUNK + pool_top[c]] = SLOT_W'(slot);
                if (held_total > 0)
                    held_total--;
            end
        end
        r.count = COUNT_W'(held_total);
        return r;
    endfunction

    function automatic int pick_held_slot();
        int held [$];
        for (int k = 0; k < POOL_SLOTS; k++)
            if (slot_held[k])
                held.push_back(k);
        if (held.size() == 0)
            return -1;
        return held[$urandom_range(held.size() - 1)];
    endfunction

    function automatic int idle_len();
        if ($urandom_range(99) < 85)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic add_req(input logic kind, input int h, input bit typed,
                           input logic [STATUS_W-1:0] st, input int gr, input int cnt);
        plan_row_t row;
        row.what   = ROW_REQ;
        row.cfg    = '0;
        row.kind   = kind;
        row.handle = HANDLE_W'(h);
        row.typed  = typed;
        row.want   = '{status: st, granted: HANDLE_W'(gr), count: COUNT_W'(cnt)};
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg(input int v);
        plan_row_t row;
        row.what   = ROW_CFG;
        row.cfg    = CFG_W'(v);
        row.kind   = KIND_ALLOC;
        row.handle = '0;
        row.typed  = 1'b0;
        row.want   = '0;
        directed_rows.push_back(row);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic offer(input logic kind, input logic [HANDLE_W-1:0] h,
                         input bit typed, input alloc_result_t typed_want);
        alloc_result_t r;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= S_TDATA_W'(h);
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        r = allocator_step(kind, h);
        awaited_grants.push_back(typed ? typed_want : r);
        @(negedge i_clk);
    endtask

    task automatic sender_rest();
        if (tx_idle_on && $urandom_range(99) < 35) begin
            s_axis_tvalid <= 1'b0;
            repeat (idle_len()) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (awaited_grants.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_chunk_slots(input logic [CFG_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        i_cfg_wdata <= v;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        chunk_size = v;
        @(negedge i_clk);
    endtask

    // receiver: random backpressure plus an occasional long hold
    initial begin
        m_axis_tready  = 1'b0;
        long_hold_seen = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req != long_hold_seen) begin
                long_hold_seen = long_hold_req;
                m_axis_tready <= 1'b0;
                repeat (60) @(negedge i_clk);
            end else if (rx_idle_on && $urandom_range(99) < 30) begin
                m_axis_tready <= 1'b0;
                repeat (idle_len()) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        alloc_result_t want;
        alloc_result_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status  = m_axis_tdata[1:0];
            got.granted = m_axis_tdata[8:2];
            got.count   = m_axis_tdata[16:9];
            if (awaited_grants.size() == 0) begin
                $error("result transaction with nothing pending: status %0d handle %0d",
                       got.status, got.granted);
                fail_count++;
            end else begin
                want = awaited_grants.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.granted !== want.granted) begin
                    $error("granted_handle: expected %0d, got %0d", want.granted, got.granted);
                    fail_count++;
                end
                if (got.count !== want.count) begin
                    $error("allocated_count: expected %0d, got %0d", want.count, got.count);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int            p;
        int            n;
        int            roll;
        int            h;
        int            phase_cfg [10];
        int            phase_bias [10];
        plan_row_t     row;
        fail_count    = 0;
        long_hold_req = 0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_ALLOC;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        for (int c = 0; c < MAX_CHUNKS; c++)
            reload_chunk(c);
        live_chunks = 1;
        held_total  = 0;
        chunk_size  = CHUNK_SLOTS_RESET;

        phase_cfg  = '{1, 31, 0, 16, 5, 0, 2, 16, 0, 31};
        phase_bias = '{70, 90, 40, 85, 30, 60, 90, 20, 75, 50};
        phase_cfg[5] = $urandom_range(31);
        phase_cfg[8] = $urandom_range(31);

        add_req(KIND_ALLOC, 127, 1, STATUS_OK, 0, 1);
        add_req(KIND_FREE,  0,   1, STATUS_OK, 0, 0);
        add_req(KIND_FREE,  0,   1, STATUS_BAD_FREE, 0, 0);    // not allocated
        add_req(KIND_FREE,  127, 1, STATUS_BAD_FREE, 0, 0);    // chunk not active
        add_cfg(1);
        add_req(KIND_ALLOC, 0,   1, STATUS_OK, 0, 1);
        add_req(KIND_ALLOC, 0,   1, STATUS_OK, 16, 2);         // opens chunk 1
        add_cfg(0);                                            // behaves as 1
        add_req(KIND_ALLOC, 85,  1, STATUS_OK, 32, 3);
        add_cfg(31);                                           // clamps to 16
        add_req(KIND_ALLOC, 0,   0, STATUS_OK, 0, 0);
        add_req(KIND_FREE,  16,  0, STATUS_OK, 0, 0);          // held across size change
        add_req(KIND_FREE,  85,  1, STATUS_BAD_FREE, 0, 3);
        add_cfg(1);
        for (int k = 0; k < 6; k++)
            add_req(KIND_ALLOC, 0, 0, STATUS_OK, 0, 0);
        add_req(KIND_ALLOC, 0,   1, STATUS_FULL, 0, 9);        // all eight chunks in use
        add_req(KIND_FREE,  112, 0, STATUS_OK, 0, 0);
        add_cfg(16);
        add_req(KIND_ALLOC, 64,  0, STATUS_OK, 0, 0);

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.what == ROW_CFG) begin
                write_chunk_slots(row.cfg);
            end else begin
                offer(row.kind, row.handle, row.typed, row.want);
                sender_rest();
            end
        end

        for (p = 0; p < 10; p++) begin
            write_chunk_slots(CFG_W'(phase_cfg[p]));
            tx_idle_on = (p != 1 && p != 3);
            rx_idle_on = (p != 3);
            for (n = 0; n < 53; n++) begin
                // receiver stops while input keeps coming, so the block backs up
                if (p == 1 && n == 6)
                    long_hold_req++;
                if (p == 6 && n == 25) begin
                    s_axis_tvalid <= 1'b0;
                    wait_drained();
                end
                roll = $urandom_range(99);
                h    = pick_held_slot();
                if (roll < 8)
                    offer(KIND_FREE, HANDLE_W'($urandom_range(127)), 0, '0);
                else if (roll < 8 + phase_bias[p] || h < 0)
                    offer(KIND_ALLOC, HANDLE_W'($urandom_range(127)), 0, '0);
                else
                    offer(KIND_FREE, HANDLE_W'(h), 0, '0);
                sender_rest();
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/csa_pkg.sv
hw/rtl/csa_slot_store.sv
hw/rtl/chunked_slot_allocator_core.sv
dv/testbench.sv
